[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the gesture detector checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define AST_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define AST_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/bgd_pkg.sv]
// ---------------------------------------------------------------------------
// bgd_pkg
// Types and constants of the button gesture detector.
// ---------------------------------------------------------------------------
package bgd_pkg;

    localparam int TIME_W  = 32;
    localparam int CLICK_W = 8;
    localparam int CFG_W   = 16;
    localparam int EN_W    = 3;

    // Register indexes
    localparam logic [2:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] CFG_LONG       = 3'd1;
    localparam logic [2:0] CFG_SUPER      = 3'd2;
    localparam logic [2:0] CFG_WINDOW     = 3'd3;
    localparam logic [2:0] CFG_MAX_CLICKS = 3'd4;
    localparam logic [2:0] CFG_EVENT_EN   = 3'd5;
    localparam logic [2:0] CFG_GROUP_EN   = 3'd6;
    localparam logic [2:0] CFG_COMBO      = 3'd7;

    // Event codes
    localparam logic [2:0] EV_DOWN     = 3'd0;
    localparam logic [2:0] EV_UP       = 3'd1;
    localparam logic [2:0] EV_MULTI    = 3'd2;
    localparam logic [2:0] EV_LONG     = 3'd3;
    localparam logic [2:0] EV_LONG_UP  = 3'd4;
    localparam logic [2:0] EV_SUPER_UP = 3'd5;

    // event_enable bits
    localparam int EN_LONG_HOLD = 0;
    localparam int EN_LONG_UP   = 1;
    localparam int EN_SUPER_UP  = 2;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PRESS   = 3'd1,
        ST_RELEASE = 3'd2,
        ST_LONG    = 3'd3,
        ST_SUPER   = 3'd4
    } bgd_state_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              level_active;
        logic              peer_busy;
    } bgd_in_t;

    typedef struct packed {
        logic [2:0]         event_code;
        logic               suppressed;
        logic [CLICK_W-1:0] click_total;
        logic [TIME_W-1:0]  hold_time;
        logic               is_pressed;
        logic               last_of_scan;
    } bgd_out_t;

endpackage

[rtl/button_gesture_detector_top.sv]
// ---------------------------------------------------------------------------
// button_gesture_detector_top
// Debounce, multi-click and long-press detector for one key.
// ---------------------------------------------------------------------------
// Each accepted scan word (timestamp, pressed level, peer-busy flag) runs the
// five-state key machine: the state registers update at the
// accepting edge and the zero, one or two events that the scan causes are
// written into a three-entry result queue whose head drives m_data. A scan
// can be taken every cycle while s_ready is high; a scan that fires two
// events leaves two words to drain. s_ready is high while the queue holds at
// most one word, so with a free-flowing sink the block sustains one scan per
// cycle for scans that fire at most one event; each two-event scan drops
// s_ready until the queue is back to one word, and a back-pressured sink
// holds the input off once two or more words wait. All time differences are
// 32-bit modulo subtractions compared against the 16-bit registers.
// Configuration writes land at the edge with cfg_we high and take effect
// from the next scan; they are meant for idle periods only.
// ---------------------------------------------------------------------------
module button_gesture_detector_top
    import bgd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // scan input
    input  logic                s_valid,
    output logic                s_ready,
    input  bgd_in_t             s_data,
    // event output
    output logic                m_valid,
    input  logic                m_ready,
    output bgd_out_t            m_data
);

    localparam int QDEPTH = 3;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0]   debounce_time_reg;
    logic [CFG_W-1:0]   long_time_reg;
    logic [CFG_W-1:0]   super_time_reg;
    logic [CFG_W-1:0]   click_window_reg;
    logic [CLICK_W-1:0] max_clicks_reg;
    logic [EN_W-1:0]    event_enable_reg;
    logic               group_enable_reg;
    logic               combo_exempt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg <= CFG_W'(20);
            long_time_reg     <= CFG_W'(1000);
            super_time_reg    <= '0;
            click_window_reg  <= CFG_W'(300);
            max_clicks_reg    <= '0;
            event_enable_reg  <= '0;
            group_enable_reg  <= 1'b0;
            combo_exempt_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE:   debounce_time_reg <= cfg_wdata;
                CFG_LONG:       long_time_reg     <= cfg_wdata;
                CFG_SUPER:      super_time_reg    <= cfg_wdata;
                CFG_WINDOW:     click_window_reg  <= cfg_wdata;
                CFG_MAX_CLICKS: max_clicks_reg    <= cfg_wdata[CLICK_W-1:0];
                CFG_EVENT_EN:   event_enable_reg  <= cfg_wdata[EN_W-1:0];
                CFG_GROUP_EN:   group_enable_reg  <= cfg_wdata[0];
                CFG_COMBO:      combo_exempt_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- key state ----------------
    bgd_state_t         state_reg, state_next;
    logic               dvalid_reg, dvalid_next;     // debounce timer running
    logic [TIME_W-1:0]  dstart_reg, dstart_next;     // debounce start time
    logic [TIME_W-1:0]  press_begin_reg, press_begin_next;
    logic [TIME_W-1:0]  window_begin_reg, window_begin_next;
    logic [CLICK_W-1:0] click_reg, click_next;
    logic [TIME_W-1:0]  hold_reg, hold_next;
    logic               group_hit_reg, group_hit_next;

    logic s_fire, m_fire;
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    logic [TIME_W-1:0] now;
    logic              active;
    assign now    = s_data.now_ms;
    assign active = s_data.level_active;

    // Elapsed times, modulo 2^32
    logic [TIME_W-1:0] since_deb, since_press, since_window;
    assign since_deb    = now - dstart_reg;
    assign since_press  = now - press_begin_reg;
    assign since_window = now - window_begin_reg;

    logic settle_ok, long_hit, super_hit, window_hit, multi_ok;
    assign settle_ok  = dvalid_reg && (since_deb >= TIME_W'(debounce_time_reg));
    assign long_hit   = since_press >= TIME_W'(long_time_reg);
    assign super_hit  = (super_time_reg != '0) && (since_press >= TIME_W'(super_time_reg));
    assign window_hit = since_window >= TIME_W'(click_window_reg);
    assign multi_ok   = (max_clicks_reg == '0) || (click_reg <= max_clicks_reg);

    // Sticky group hit, cleared while idle
    assign group_hit_next = (state_reg == ST_IDLE) ? 1'b0
                          : (group_hit_reg || (group_enable_reg && s_data.peer_busy));
    // Hold time refreshes while the key is held
    assign hold_next = (state_reg == ST_PRESS || state_reg == ST_LONG ||
                        state_reg == ST_SUPER) ? since_press : hold_reg;

    // Next state and timers
    always_comb begin
        state_next        = state_reg;
        dvalid_next       = dvalid_reg;
        dstart_next       = dstart_reg;
        press_begin_next  = press_begin_reg;
        window_begin_next = window_begin_reg;
        click_next        = click_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (active) begin
                    if (!dvalid_reg) begin
                        dvalid_next = 1'b1;
                        dstart_next = now;
                    end else if (settle_ok) begin
                        dvalid_next       = 1'b0;
                        press_begin_next  = now;
                        window_begin_next = now;
                        state_next        = ST_PRESS;
                    end
                end else begin
                    dvalid_next = 1'b0;
                end
            end
            ST_PRESS: begin
                if (!active) begin
                    if (!dvalid_reg) begin
                        dvalid_next = 1'b1;
                        dstart_next = now;
                    end else if (settle_ok) begin
                        dvalid_next       = 1'b0;
                        click_next        = click_reg + 1'b1;
                        window_begin_next = now;
                        state_next        = ST_RELEASE;
                    end
                end else begin
                    dvalid_next = 1'b0;
                    if (long_hit) begin
                        click_next = '0;
                        state_next = ST_LONG;
                    end
                end
            end
            ST_RELEASE: begin
                if (active) begin
                    dvalid_next       = 1'b0;
                    press_begin_next  = now;
                    window_begin_next = now;
                    state_next        = ST_PRESS;
                end else if (window_hit) begin
                    click_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_LONG, ST_SUPER: begin
                if (!active) begin
                    if (!dvalid_reg) begin
                        dvalid_next = 1'b1;
                        dstart_next = now;
                    end else if (settle_ok) begin
                        dvalid_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    dvalid_next = 1'b0;
                    if (state_reg == ST_LONG && super_hit) begin
                        state_next = ST_SUPER;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Events of this scan
    logic [1:0] ev_cnt;
    logic [2:0] ev0_code, ev1_code;

    always_comb begin
        ev_cnt   = 2'd0;
        ev0_code = EV_UP;
        ev1_code = EV_UP;
        unique case (state_reg)
            ST_IDLE: begin
                if (active && settle_ok) begin
                    ev_cnt   = 2'd1;
                    ev0_code = EV_DOWN;
                end
            end
            ST_PRESS: begin
                if (active && long_hit && event_enable_reg[EN_LONG_HOLD]) begin
                    ev_cnt   = 2'd1;
                    ev0_code = EV_LONG;
                end
            end
            ST_RELEASE: begin
                if (active) begin
                    ev_cnt   = 2'd1;
                    ev0_code = EV_DOWN;
                end else if (window_hit) begin
                    if (multi_ok) begin
                        ev_cnt   = 2'd2;
                        ev0_code = EV_MULTI;
                    end else begin
                        ev_cnt = 2'd1;
                    end
                end
            end
            ST_LONG: begin
                if (!active && settle_ok) begin
                    if (event_enable_reg[EN_LONG_UP]) begin
                        ev_cnt   = 2'd2;
                        ev0_code = EV_LONG_UP;
                    end else begin
                        ev_cnt = 2'd1;
                    end
                end
            end
            ST_SUPER: begin
                if (!active && settle_ok) begin
                    if (event_enable_reg[EN_SUPER_UP]) begin
                        ev_cnt   = 2'd2;
                        ev0_code = EV_SUPER_UP;
                    end else if (event_enable_reg[EN_LONG_UP]) begin
                        ev_cnt   = 2'd2;
                        ev0_code = EV_LONG_UP;
                    end else begin
                        ev_cnt = 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Shared event fields; long entry reports a cleared count
    bgd_out_t ev0, ev1;
    logic               ev_supp;
    logic [CLICK_W-1:0] ev_clicks;
    assign ev_supp   = group_hit_next && !combo_exempt_reg;
    assign ev_clicks = (state_reg == ST_PRESS) ? '0 : click_reg;

    always_comb begin
        ev0.event_code   = ev0_code;
        ev0.suppressed   = ev_supp;
        ev0.click_total  = ev_clicks;
        ev0.hold_time    = hold_next;
        ev0.is_pressed   = active;
        ev0.last_of_scan = (ev_cnt == 2'd1);
        ev1              = ev0;
        ev1.event_code   = ev1_code;
        ev1.last_of_scan = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            dvalid_reg       <= 1'b0;
            dstart_reg       <= '0;
            press_begin_reg  <= '0;
            window_begin_reg <= '0;
            click_reg        <= '0;
            hold_reg         <= '0;
            group_hit_reg    <= 1'b0;
        end else if (s_fire) begin
            state_reg        <= state_next;
            dvalid_reg       <= dvalid_next;
            dstart_reg       <= dstart_next;
            press_begin_reg  <= press_begin_next;
            window_begin_reg <= window_begin_next;
            click_reg        <= click_next;
            hold_reg         <= hold_next;
            group_hit_reg    <= group_hit_next;
        end
    end

    // ---------------- result queue ----------------
    // Entry 0 is the head; entries shift down on a pop.
    bgd_out_t   q_reg [QDEPTH];
    bgd_out_t   q_next [QDEPTH];
    bgd_out_t   q_kept [QDEPTH];
    logic [1:0] count_reg, count_next, count_pop;

    assign s_ready   = (count_reg <= 2'd1);
    assign m_valid   = (count_reg != 2'd0);
    assign m_data    = q_reg[0];
    assign count_pop = count_reg - {1'b0, m_fire};

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (m_fire && i < QDEPTH - 1) begin
                q_kept[i] = q_reg[i+1];
            end else begin
                q_kept[i] = q_reg[i];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            if (s_fire && 2'(i) == count_pop) begin
                q_next[i] = ev0;
            end else if (s_fire && 2'(i) == count_pop + 2'd1) begin
                q_next[i] = ev1;
            end else begin
                q_next[i] = q_kept[i];
            end
        end
        count_next = count_pop + (s_fire ? ev_cnt : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

[rtl/bgd_checker.sv]
// ---------------------------------------------------------------------------
// bgd_checker
// Port-level checks of the gesture detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bgd_checker
    import bgd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input bgd_out_t            m_data
);

    // stalled event word holds
    `AST_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // input stalls only while events are waiting
    `AST_IMPL(a_stall_has_data, aclk, aresetn, !s_ready, m_valid)

    // first of a pair is followed at once by its press-up partner
    `AST_NEXT(a_pair_follows, aclk, aresetn, m_valid && m_ready && !m_data.last_of_scan,
              m_valid && m_data.event_code == EV_UP)

    // only defined event codes leave
    `AST_IMPL(a_code_range, aclk, aresetn, m_valid, m_data.event_code <= EV_SUPER_UP)

endmodule

bind button_gesture_detector_top bgd_checker u_bgd_checker (.*);

[verif/bgd_event_checker.sv]
// ---------------------------------------------------------------------------
// bgd_event_checker
// Watches the scan, event and register ports of the gesture detector, keeps
// its own model of the key machine and compares every event word it sees.
// ---------------------------------------------------------------------------
module bgd_event_checker
    import bgd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  bgd_in_t          s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  bgd_out_t         m_data,
    output int               n_errors,
    output int               n_pending,
    output int               n_events
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [15:0]        deb_ms, long_ms, xlong_ms, window_ms;
    logic [7:0]         max_clicks;
    logic [EN_W-1:0]    ev_en;
    logic               grp_en, combo;

    // key machine copy
    bgd_state_t         key_st;
    logic [TIME_W-1:0]  deb_t0, press_t0, win_t0, hold_ms;
    logic               deb_run, grp_hit, lvl_seen;
    logic [CLICK_W-1:0] clicks;

    bgd_out_t           event_q[$];
    int                 err_cnt, ev_cnt;

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // debounce timer: true once the changed level has persisted
    function automatic logic settled(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] dt;
        dt = t - deb_t0;
        if (!deb_run) begin
            deb_run = 1'b1;
            deb_t0  = t;
            return 1'b0;
        end
        if (dt >= TIME_W'(deb_ms)) begin
            deb_run = 1'b0;
            deb_t0  = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_timer();
        deb_run = 1'b0;
        deb_t0  = '0;
    endfunction

    function automatic bgd_out_t make_event(input logic [2:0] code);
        bgd_out_t e;
        e.event_code   = code;
        e.suppressed   = grp_hit && !combo;
        e.click_total  = clicks;
        e.hold_time    = hold_ms;
        e.is_pressed   = lvl_seen;
        e.last_of_scan = 1'b0;
        return e;
    endfunction

    task automatic advance_key(input bgd_in_t w);
        bgd_out_t          evs[2];
        int                n;
        logic              act;
        logic [TIME_W-1:0] t;
        n   = 0;
        act = w.level_active;
        t   = w.now_ms;
        if (key_st == ST_IDLE)
            grp_hit = 1'b0;
        else if (grp_en && w.peer_busy)
            grp_hit = 1'b1;
        if (key_st != ST_IDLE && key_st != ST_RELEASE)
            hold_ms = t - press_t0;
        lvl_seen = act;
        case (key_st)
            ST_IDLE: begin
                if (act) begin
                    if (settled(t)) begin
                        press_t0 = t;
                        win_t0   = t;
                        key_st   = ST_PRESS;
                        evs[n]   = make_event(EV_DOWN);
                        n++;
                    end
                end else begin
                    clear_timer();
                end
            end
            ST_PRESS: begin
                if (!act) begin
                    if (settled(t)) begin
                        clicks = clicks + 1'b1;
                        win_t0 = t;
                        key_st = ST_RELEASE;
                    end
                end else begin
                    clear_timer();
                    if (t - press_t0 >= TIME_W'(long_ms)) begin
                        clicks = '0;
                        key_st = ST_LONG;
                        if (ev_en[EN_LONG_HOLD]) begin
                            evs[n] = make_event(EV_LONG);
                            n++;
                        end
                    end
                end
            end
            ST_RELEASE: begin
                if (act) begin
                    clear_timer();
                    press_t0 = t;
                    win_t0   = t;
                    key_st   = ST_PRESS;
                    evs[n]   = make_event(EV_DOWN);
                    n++;
                end else if (t - win_t0 >= TIME_W'(window_ms)) begin
                    if (max_clicks == 0 || clicks <= max_clicks) begin
                        evs[n] = make_event(EV_MULTI);
                        n++;
                    end
                    evs[n] = make_event(EV_UP);
                    n++;
                    clicks = '0;
                    key_st = ST_IDLE;
                end
            end
            ST_LONG: begin
                if (!act) begin
                    if (settled(t)) begin
                        key_st = ST_IDLE;
                        if (ev_en[EN_LONG_UP]) begin
                            evs[n] = make_event(EV_LONG_UP);
                            n++;
                        end
                        evs[n] = make_event(EV_UP);
                        n++;
                    end
                end else begin
                    clear_timer();
                    if (xlong_ms != 0 && t - press_t0 >= TIME_W'(xlong_ms))
                        key_st = ST_SUPER;
                end
            end
            ST_SUPER: begin
                if (!act) begin
                    if (settled(t)) begin
                        key_st = ST_IDLE;
                        if (ev_en[EN_SUPER_UP]) begin
                            evs[n] = make_event(EV_SUPER_UP);
                            n++;
                        end else if (ev_en[EN_LONG_UP]) begin
                            evs[n] = make_event(EV_LONG_UP);
                            n++;
                        end
                        evs[n] = make_event(EV_UP);
                        n++;
                    end
                end else begin
                    clear_timer();
                end
            end
            default: key_st = ST_IDLE;
        endcase
        if (n > 0)
            evs[n-1].last_of_scan = 1'b1;
        for (int i = 0; i < n; i++)
            event_q.push_back(evs[i]);
    endtask

    initial begin
        err_cnt = 0;
        ev_cnt  = 0;
    end

    always @(posedge aclk) begin
        bgd_out_t want;
        if (!aresetn) begin
            deb_ms     = 16'd20;
            long_ms    = 16'd1000;
            xlong_ms   = 16'd0;
            window_ms  = 16'd300;
            max_clicks = '0;
            ev_en      = '0;
            grp_en     = 1'b0;
            combo      = 1'b0;
            key_st     = ST_IDLE;
            deb_t0     = '0;
            deb_run    = 1'b0;
            press_t0   = '0;
            win_t0     = '0;
            clicks     = '0;
            hold_ms    = '0;
            grp_hit    = 1'b0;
            lvl_seen   = 1'b0;
            event_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                ev_cnt++;
                if (event_q.size() == 0) begin
                    report_mismatch($sformatf("event word %0d with nothing expected", ev_cnt));
                end else begin
                    want = event_q.pop_front();
                    if (m_data.event_code !== want.event_code)
                        report_mismatch($sformatf("word %0d event_code %0d, want %0d",
                            ev_cnt, m_data.event_code, want.event_code));
                    if (m_data.suppressed !== want.suppressed)
                        report_mismatch($sformatf("word %0d suppressed %0b, want %0b",
                            ev_cnt, m_data.suppressed, want.suppressed));
                    if (m_data.click_total !== want.click_total)
                        report_mismatch($sformatf("word %0d click_total %0d, want %0d",
                            ev_cnt, m_data.click_total, want.click_total));
                    if (m_data.hold_time !== want.hold_time)
                        report_mismatch($sformatf("word %0d hold_time %0d, want %0d",
                            ev_cnt, m_data.hold_time, want.hold_time));
                    if (m_data.is_pressed !== want.is_pressed)
                        report_mismatch($sformatf("word %0d is_pressed %0b, want %0b",
                            ev_cnt, m_data.is_pressed, want.is_pressed));
                    if (m_data.last_of_scan !== want.last_of_scan)
                        report_mismatch($sformatf("word %0d last_of_scan %0b, want %0b",
                            ev_cnt, m_data.last_of_scan, want.last_of_scan));
                end
            end
            // a scan accepted at this edge sees the old register values
            if (s_valid && s_ready)
                advance_key(s_data);
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DEBOUNCE:   deb_ms     = cfg_wdata;
                    CFG_LONG:       long_ms    = cfg_wdata;
                    CFG_SUPER:      xlong_ms   = cfg_wdata;
                    CFG_WINDOW:     window_ms  = cfg_wdata;
                    CFG_MAX_CLICKS: max_clicks = cfg_wdata[7:0];
                    CFG_EVENT_EN:   ev_en      = cfg_wdata[EN_W-1:0];
                    CFG_GROUP_EN:   grp_en     = cfg_wdata[0];
                    CFG_COMBO:      combo      = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        n_errors  <= err_cnt;
        n_pending <= event_q.size();
        n_events  <= ev_cnt;
    end

endmodule

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the button gesture detector.
// ---------------------------------------------------------------------------
// Drives scan words through the valid/ready input with random gaps, drains
// event words with random stalls, and reprograms the registers between
// phases while nothing is in flight. A directed opening walks through every
// event kind, timestamp wrap, bounce and suppression; a click storm wraps the
// click counter; the rest is random press/release gestures with bounce and
// noise under a set of register settings that includes both extremes. The
// checker beside the block predicts and compares every event word.
// ---------------------------------------------------------------------------
module tb_top;
    import bgd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [2:0]       cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    bgd_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    bgd_out_t         m_data;

    int               n_errors, n_pending, n_events;

    // stimulus bookkeeping
    logic [TIME_W-1:0] scan_ms;      // running timestamp of the next scan
    int                n_scans;
    int                n_settings;
    bit                steady;       // phase with no gaps and no stalls
    int                scale, ph, k;
    logic [15:0]       r_deb, r_long, r_super, r_win;

    button_gesture_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    bgd_event_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .n_errors  (n_errors),
        .n_pending (n_pending),
        .n_events  (n_events)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL button_gesture_detector_top");
        $finish;
    end

    // More than half the draws are zero so back-to-back traffic is common.
    function automatic int draw_wait();
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Event sink: stall for a drawn number of cycles, then take one word.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            int stall;
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // One scan word. s_valid stays high across back-to-back words; it only
    // drops when a gap is drawn, so it never gets two updates in one step.
    task automatic send_scan(input logic [TIME_W-1:0] t, input logic lvl, input logic peer);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_data.now_ms       <= t;
        s_data.level_active <= lvl;
        s_data.peer_busy    <= peer;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_scans++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Reprogram every register once the event stream has fully drained.
    // A scan that fires nothing leaves no trace in n_pending, so a few extra
    // cycles cover the block's registered key state.
    task automatic apply_cfg(input logic [15:0] deb, input logic [15:0] lng,
                             input logic [15:0] sup, input logic [15:0] win,
                             input logic [7:0] maxc, input logic [2:0] en,
                             input logic grp, input logic cmb);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG, lng);
        write_reg(CFG_SUPER, sup);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_MAX_CLICKS, CFG_W'(maxc));
        write_reg(CFG_EVENT_EN, CFG_W'(en));
        write_reg(CFG_GROUP_EN, CFG_W'(grp));
        write_reg(CFG_COMBO, CFG_W'(cmb));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly short steps so debounce and windows resolve inside a gesture,
    // some long ones to cross the hold thresholds, and rare jumps anywhere
    // in the 32-bit range so timestamps wrap and every bit toggles.
    task automatic step_time(input int sc);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            scan_ms = $urandom();
        else if (r < 72)
            scan_ms += $urandom_range(0, sc / 8 + 2);
        else if (r < 92)
            scan_ms += $urandom_range(0, sc);
        else
            scan_ms += $urandom_range(0, 3 * sc);
    endtask

    // Press/release gestures with bounce; some holds run long enough for
    // long and super hold; about one gesture in seven is pure noise.
    task automatic run_gestures(input int n_items, input int sc);
        int   sent, p_len, r_len, i;
        bit   noisy;
        logic lvl;
        sent = 0;
        while (sent < n_items) begin
            noisy = ($urandom_range(0, 99) < 15);
            p_len = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
            r_len = $urandom_range(1, 12);
            for (i = 0; i < p_len + r_len; i++) begin
                if (noisy) begin
                    lvl = 1'($urandom_range(0, 1));
                end else begin
                    lvl = (i < p_len);
                    if ($urandom_range(0, 99) < 8)
                        lvl = !lvl;
                end
                step_time(sc);
                send_scan(scan_ms, lvl, $urandom_range(0, 99) < 20);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_DEBOUNCE;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        n_scans    = 0;
        n_settings = 0;
        steady     = 1'b0;
        scan_ms    = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed walk: debounce 5, long 50, super 80, window 20 ----
        apply_cfg(16'd5, 16'd50, 16'd80, 16'd20, 8'd0, 3'b111, 1'b1, 1'b0);
        send_scan(32'hFFFF_FFF0, 1'b1, 1'b0);  // debounce starts
        send_scan(32'hFFFF_FFFF, 1'b1, 1'b0);  // press down at top of range
        send_scan(32'h0000_0000, 1'b0, 1'b1);  // hold wraps; peer marks group
        send_scan(32'd8,  1'b0, 1'b0);         // release settles, click 1
        send_scan(32'd10, 1'b1, 1'b0);         // press inside window, no debounce
        send_scan(32'd15, 1'b0, 1'b0);
        send_scan(32'd22, 1'b0, 1'b0);         // click 2
        send_scan(32'd50, 1'b0, 1'b0);         // window timeout: multi + up
        send_scan(32'd60, 1'b1, 1'b0);         // idle bounce: start,
        send_scan(32'd62, 1'b0, 1'b0);         //   level drops, timer cleared,
        send_scan(32'd64, 1'b1, 1'b0);         //   start again
        send_scan(32'd70, 1'b1, 1'b0);         // press down
        send_scan(32'd130, 1'b1, 1'b0);        // long press
        send_scan(32'd160, 1'b1, 1'b0);        // into super hold
        send_scan(32'd165, 1'b0, 1'b0);        // release bounce in super hold
        send_scan(32'd166, 1'b1, 1'b0);
        send_scan(32'd170, 1'b0, 1'b0);
        send_scan(32'd180, 1'b0, 1'b0);        // super long up + up
        // long-up path without the on-hold event
        apply_cfg(16'd5, 16'd50, 16'd80, 16'd20, 8'd0, 3'b010, 1'b1, 1'b0);
        send_scan(32'd200, 1'b1, 1'b0);
        send_scan(32'd210, 1'b1, 1'b0);        // press down
        send_scan(32'd270, 1'b1, 1'b0);        // long hold, silent
        send_scan(32'd280, 1'b0, 1'b1);        // group hit while held
        send_scan(32'd290, 1'b0, 1'b0);        // long up + up, suppressed

        // ---- extremes and the reset time settings ----
        apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 3'b000, 1'b0, 1'b0);
        run_gestures(68, 8);
        apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 3'b111, 1'b1, 1'b1);
        run_gestures(68, 65536);
        apply_cfg(16'd20, 16'd1000, 16'd0, 16'd300, 8'd0, 3'b001, 1'b1, 1'b0);
        run_gestures(68, 1000);

        // ---- click storm: over 256 clicks in one window wraps the count ----
        apply_cfg(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd200, 3'($urandom_range(0, 7)),
                  1'b1, 1'($urandom_range(0, 1)));
        scan_ms = $urandom();
        for (k = 0; k < 2; k++) begin
            scan_ms += 1;
            send_scan(scan_ms, 1'b1, 1'b0);
        end
        for (k = 0; k < 262; k++) begin
            scan_ms += 1;
            send_scan(scan_ms, 1'b0, $urandom_range(0, 99) < 5);
            scan_ms += 1;
            send_scan(scan_ms, 1'b0, 1'b0);
            scan_ms += 1;
            send_scan(scan_ms, 1'b1, 1'b0);
        end
        for (k = 0; k < 2; k++) begin
            scan_ms += 1;
            send_scan(scan_ms, 1'b0, 1'b0);
        end
        scan_ms += 70000;
        send_scan(scan_ms, 1'b0, 1'b0);        // window closes: multi + up

        // ---- random settings at gesture-sized times ----
        for (ph = 0; ph < 8; ph++) begin
            r_deb   = 16'($urandom_range(0, 6));
            r_long  = 16'($urandom_range(5, 80));
            r_super = ($urandom_range(0, 2) == 0) ? 16'd0
                    : 16'(r_long + $urandom_range(0, 60));
            r_win   = 16'($urandom_range(2, 30));
            steady  = (ph % 4 == 3);
            apply_cfg(r_deb, r_long, r_super, r_win, 8'($urandom_range(0, 4)),
                      3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            scale = r_long + r_super + r_win + r_deb;
            run_gestures(68, scale);
        end
        steady = 1'b0;

        // drain, then give the pipeline a few more cycles
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d scan words under %0d register settings; %0d event words checked.",
                 n_scans, n_settings, n_events);
        if (n_errors == 0) begin
            $display("PASS button_gesture_detector_top");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAIL button_gesture_detector_top");
        end
        $finish;
    end

endmodule
